// ----- design/ufda_pkg.sv -----
// ----------------------------------------------------------------------------
// ufda_pkg: shared types and constants for the decimal ASCII converter
// Digit storage layout, queue entry format and the BCD adjust helper.
// ----------------------------------------------------------------------------
package ufda_pkg;

   localparam int VALUE_W    = 32;
   localparam int NUM_DIGITS = 10;
   localparam int DIGIT_W    = 4;
   localparam int CHAR_W     = 6;
   localparam int POS_W      = $clog2(NUM_DIGITS);
   localparam int SHIFT_CNT_W = $clog2(VALUE_W);

   localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
   localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = DIGIT_W'(5);
   localparam logic [DIGIT_W-1:0] ADJ_ADD    = DIGIT_W'(3);

   typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_type;

   // One converted value waiting for the emitter.
   typedef struct packed {
      bcd_type          digits;
      logic [POS_W-1:0] msd;     // position of the leading digit
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Add three to a BCD digit of five or more before the next shift.
   function automatic logic [DIGIT_W-1:0] bcd_adjust(input logic [DIGIT_W-1:0] d);
      logic [DIGIT_W-1:0] r;
      r = (d >= ADJ_LIMIT) ? d + ADJ_ADD : d;
      return r;
   endfunction

endpackage

// ----- design/ufda_queue.sv -----
// ----------------------------------------------------------------------------
// ufda_queue: small FIFO between converter and digit emitter
// Holds converted values so each side stalls on its own.
// ----------------------------------------------------------------------------
module ufda_queue
   import ufda_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_data,
   input  logic         pop,
   output entry_type    head,
   output q_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   entry_type        entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/ufda_front.sv -----
// ----------------------------------------------------------------------------
// ufda_front: command intake and shift-add-3 binary to BCD converter
// Takes one value per command, converts it by shift-add-3, queues the digits.
// ----------------------------------------------------------------------------
module ufda_front
   import ufda_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] req_value,
   output logic               busy,
   input  q_status_type       q_status,
   output logic               push,
   output entry_type          push_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   localparam logic [SHIFT_CNT_W-1:0] LAST_SHIFT = SHIFT_CNT_W'(VALUE_W - 1);

   logic [1:0]             state_ff, state_in;
   logic [SHIFT_CNT_W-1:0] shift_cnt_ff, shift_cnt_in;
   logic [VALUE_W-1:0]     bin_ff, bin_in;
   bcd_type                bcd_ff, bcd_in;
   bcd_type                bcd_adj;
   logic [NUM_DIGITS*DIGIT_W-1:0] bcd_adj_flat;
   logic [POS_W-1:0]       msd;

   assign busy = (state_ff != ST_IDLE);

   // Adjust every digit, independent of the others.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bcd_adj[i] = bcd_adjust(bcd_ff[i]);
      end
   end

   assign bcd_adj_flat = bcd_adj;

   // Leading nonzero digit; zero keeps position zero so one '0' goes out.
   always_comb begin
      msd = '0;
      for (int i = 1; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i] != '0) begin
            msd = POS_W'(i);
         end
      end
   end

   assign push             = (state_ff == ST_PUSH) && !q_status.full;
   assign push_data.digits = bcd_ff;
   assign push_data.msd    = msd;

   always_comb begin
      state_in     = state_ff;
      shift_cnt_in = shift_cnt_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               bin_in       = req_value;
               bcd_in       = '0;
               shift_cnt_in = '0;
               state_in     = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in       = {bcd_adj_flat[NUM_DIGITS*DIGIT_W-2:0], bin_ff[VALUE_W-1]};
            bin_in       = {bin_ff[VALUE_W-2:0], 1'b0};
            shift_cnt_in = shift_cnt_ff + 1'b1;
            if (shift_cnt_ff == LAST_SHIFT) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            // hold the digits until the queue has room
            if (!q_status.full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_cnt_ff <= shift_cnt_in;
      bin_ff       <= bin_in;
      bcd_ff       <= bcd_in;
   end

endmodule

// ----- design/ufda_back.sv -----
// ----------------------------------------------------------------------------
// ufda_back: digit emitter
// Walks the queued digits from the leading one down, one character a cycle within a value.
// ----------------------------------------------------------------------------
module ufda_back
   import ufda_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  entry_type         head,
   input  q_status_type      q_status,
   output logic              pop,
   output logic              rsp_valid,
   output logic [CHAR_W-1:0] rsp_digit_char,
   output logic              rsp_last_digit
);

   logic              active_ff, active_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              valid_ff, valid_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              last_ff, last_in;
   logic [DIGIT_W-1:0] digit;

   assign digit = head.digits[pos_ff];

   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      valid_in  = 1'b0;
      char_in   = ASCII_ZERO + CHAR_W'(digit);
      last_in   = (pos_ff == '0);
      pop       = 1'b0;
      if (!active_ff) begin
         if (!q_status.empty) begin
            active_in = 1'b1;
            pos_in    = head.msd;
         end
      end else begin
         valid_in = 1'b1;
         if (pos_ff == '0) begin
            active_in = 1'b0;
            pop       = 1'b1;
         end else begin
            pos_in = pos_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last_digit = last_ff;

endmodule

// ----- design/uint_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// uint_to_decimal_ascii: unsigned 32-bit value to decimal ASCII digits
// Converter front end, digit queue and character emitter.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_value and raise start; the value transfers at
//   the rising edge where start is high and busy is low.
//   Result channel: each digit character shows on rsp_digit_char for one
//   cycle with rsp_valid high, leading digit first, no leading zeros; zero
//   gives a single '0'. rsp_last_digit marks the final digit of a value.
//   The receiver cannot stall: every strobed character is a transfer.
// Operation:
//   The front end runs the shift-add-3 steps, then queues the digits; busy
//   stays high from a transfer until the digits are queued (longer if the
//   queue is full). No new command is taken until then.
//   The emitter loads a queued value, then sends one character a cycle
//   until the last digit of that value.
// Reset:
//   Synchronous, active high; clears the converter, queue and emitter.
// ----------------------------------------------------------------------------
module uint_to_decimal_ascii
   import ufda_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   output logic [CHAR_W-1:0]  rsp_digit_char,
   output logic               rsp_last_digit
);

   q_status_type q_status;
   logic         push, pop;
   entry_type    push_data, head;

   // Intake and BCD conversion.
   ufda_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_value (req_value),
      .busy      (busy),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   // Decouple conversion from emission.
   ufda_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   // Send characters most significant first.
   ufda_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule

// ----- design/ufda_checker.sv -----
// ----------------------------------------------------------------------------
// ufda_checker: port-level checks for the decimal ASCII converter
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module ufda_checker
   import ufda_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [CHAR_W-1:0]  rsp_digit_char,
   input logic               rsp_last_digit
);

   localparam logic [CHAR_W-1:0] ASCII_NINE = CHAR_W'(57);

   // Characters are always decimal digits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_char >= ASCII_ZERO) && (rsp_digit_char <= ASCII_NINE))
      else $error("character outside '0'..'9'");

   // A command transfer makes the converter busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after command transfer");

   // Digits of one value go out back to back.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_digit) |=> rsp_valid)
      else $error("gap inside a digit string");

   // The emitter pauses after the last digit of a value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_digit) |=> !rsp_valid)
      else $error("character right after the last digit");

   // No result strobe right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe after reset");

endmodule

bind uint_to_decimal_ascii ufda_checker u_checker (.*);

// ----- tb/uint_to_decimal_ascii_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uint_to_decimal_ascii_tb: self-checking bench for the decimal ASCII converter
// Sends 32-bit values on the command port, models the digit string each one
// should produce and compares every strobed character and last-digit flag in
// order. Directed values hit zero, the largest value and the digit-count
// boundaries; random values follow in bursts with random gaps.
// ----------------------------------------------------------------------------
module uint_to_decimal_ascii_tb;
   import ufda_pkg::*;

   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 5;
   localparam int RANDOM_ITEMS  = 94;
   localparam int MAX_BURST     = 8;
   localparam int MAX_GAP       = 45;   // longer than one conversion
   localparam int DRAIN_CYCLES  = 20;   // settle time after the last character
   localparam int STALL_LIMIT   = 2000; // cycles with no transfer before giving up
   localparam int DEC_RADIX     = 10;

   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

   // One expected character on the result channel.
   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last_digit;
   } ascii_digit_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [VALUE_W-1:0] req_value;
   logic               rsp_valid;
   logic [CHAR_W-1:0]  rsp_digit_char;
   logic               rsp_last_digit;

   ascii_digit_type expected_digits[$];
   int           error_count  = 0;
   int           values_sent  = 0;
   int           digits_seen  = 0;
   int           idle_cycles  = 0;

   uint_to_decimal_ascii u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

   initial clock = 1'b0;
   always #CLK_HALF clock = ~clock;

   // ------------------------------------------------------------------------
   // Digit predictor: split the value into decimal digits, least significant
   // first, then queue them as ASCII leading digit first. Zero still yields
   // one '0', and only the final digit carries the last-digit flag.
   // ------------------------------------------------------------------------
   task automatic queue_decimal_digits(input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] rest;
      logic [DIGIT_W-1:0] lsd_first[NUM_DIGITS];
      int                 count;
      ascii_digit_type    entry;
      rest  = value;
      count = 0;
      do begin
         lsd_first[count] = DIGIT_W'(rest % DEC_RADIX);
         rest             = rest / DEC_RADIX;
         count++;
      end while (rest != 0 && count < NUM_DIGITS);
      for (int k = count - 1; k >= 0; k--) begin
         entry.digit_char = ASCII_ZERO + CHAR_W'(lsd_first[k]);
         entry.last_digit = (k == 0);
         expected_digits.push_back(entry);
      end
   endtask

   // ------------------------------------------------------------------------
   // Command side. Raise start with the value and hold it until an edge finds
   // busy low: that edge is the transfer. Start is left high on return so a
   // following send keeps the channel loaded without a gap; hold_sender drops
   // it when the burst ends.
   // ------------------------------------------------------------------------
   task automatic send_value(input logic [VALUE_W-1:0] value);
      req_value <= value;
      start     <= 1'b1;
      do @(posedge clock); while (busy);
      queue_decimal_digits(value);
      values_sent++;
   endtask

   // Drop start for a number of cycles; zero keeps the burst going.
   task automatic hold_sender(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Drop start and wait until every queued character has been checked.
   task automatic wait_for_results();
      start <= 1'b0;
      do @(posedge clock); while (expected_digits.size() != 0);
   endtask

   // Random value: mostly a chosen digit count, some near powers of ten,
   // some raw 32-bit noise.
   function automatic logic [VALUE_W-1:0] random_value();
      int              ndig;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned pow;
      ndig = $urandom_range(NUM_DIGITS, 1);
      pow  = 1;
      repeat (ndig - 1) pow = pow * DEC_RADIX;
      case ($urandom_range(3, 0))
         0: begin
            return $urandom;
         end
         1: begin
            // land on a digit-count boundary: 10^k - 1, 10^k or 10^k + 1
            if (ndig == 1) return VALUE_W'($urandom_range(1, 0));
            return VALUE_W'(pow + $urandom_range(2, 0) - 1);
         end
         default: begin
            lo = (ndig == 1) ? 0 : pow;
            hi = pow * DEC_RADIX - 1;
            if (hi > VALUE_MAX) hi = VALUE_MAX;
            return $urandom_range(32'(hi), 32'(lo));
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Result checker. The receiver cannot stall, so every strobed cycle is a
   // transfer: compare it against the oldest expected character.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      ascii_digit_type want;
      if (!reset && rsp_valid) begin
         digits_seen++;
         if (expected_digits.size() == 0) begin
            $display("%0t: unexpected character: expected none, actual char %0d last %0b",
                     $time, rsp_digit_char, rsp_last_digit);
            error_count++;
         end else begin
            want = expected_digits.pop_front();
            if (rsp_digit_char !== want.digit_char) begin
               $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                        $time, want.digit_char, rsp_digit_char);
               error_count++;
            end
            if (rsp_last_digit !== want.last_digit) begin
               $display("%0t: last_digit mismatch: expected %0b, actual %0b",
                        $time, want.last_digit, rsp_last_digit);
               error_count++;
            end
         end
      end
   end

   // Watchdog: count cycles with neither a command nor a result transfer.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d characters outstanding",
                     $time, STALL_LIMIT, expected_digits.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Zero, the largest value, several digit-count edges and alternating bit
   // patterns, sent back to back.
   task automatic test_directed_values();
      logic [VALUE_W-1:0] picks[$];
      picks = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999999,
                32'd1000000, 32'd99999999, 32'd100000000, 32'd999999999,
                32'd1000000000, 32'd1234567890, 32'd2147483647, 32'd2147483648,
                32'hAAAA_AAAA, 32'h5555_5555, 32'd4000000000, 32'd4294967294,
                VALUE_MAX, 32'd0, VALUE_MAX};
      foreach (picks[i]) send_value(picks[i]);
   endtask

   // Stop feeding until the queue drains, then resume from a fully idle block.
   task automatic test_drain_pause();
      send_value(VALUE_MAX);
      send_value(32'd7);
      wait_for_results();
      send_value(32'd0);
      send_value(32'd1000000000);
      wait_for_results();
   endtask

   // Random values in bursts; about a quarter of the gaps are zero so start
   // stays high across bursts, others are random lengths up to MAX_GAP.
   task automatic test_random_values();
      int sent;
      int burst;
      int gap;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(MAX_BURST, 1);
         for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
            send_value(random_value());
            sent++;
         end
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(MAX_GAP, 1);
         hold_sender(gap);
      end
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_value = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed_values();
      test_drain_pause();
      test_random_values();

      // Let the last characters out, then watch for stray strobes.
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d values (zero, 4294967295, power-of-ten edges, random) into",
               values_sent);
      $display("%0d checked digit characters, with burst, gap and full-drain command timing.",
               digits_seen);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
